// File: rtl/fenbb_pkg.sv
// Shared types, constants and the piece-letter decode for the FEN bitboard parser.
// No dependencies; used by fenbb_parse, fenbb_dump and fen_text_to_bitboards_core.
package fenbb_pkg;

    localparam int NUM_PIECES = 12;
    localparam int NUM_WORDS  = 15;

    localparam logic [3:0] WORD_WHITE = 4'd12;
    localparam logic [3:0] WORD_BLACK = 4'd13;
    localparam logic [3:0] WORD_ALL   = 4'd14;

    localparam logic [6:0]  EP_NONE   = 7'd65;
    localparam logic [15:0] COUNT_MAX = 16'hFFFF;
    localparam logic [3:0]  OFF_RANK  = 4'd15;
    localparam logic [3:0]  TOP_RANK  = 4'd7;
    localparam logic [3:0]  FILE_MAX  = 4'd15;
    localparam logic [2:0]  FIELD_MAX = 3'd7;

    // Field numbers, counted by spaces
    localparam logic [2:0] FIELD_PLACE  = 3'd0;
    localparam logic [2:0] FIELD_SIDE   = 3'd1;
    localparam logic [2:0] FIELD_CASTLE = 3'd2;
    localparam logic [2:0] FIELD_EP     = 3'd3;
    localparam logic [2:0] FIELD_HALF   = 3'd4;
    localparam logic [2:0] FIELD_FULL   = 3'd5;

    // Side codes
    localparam logic [1:0] SIDE_WHITE = 2'd0;
    localparam logic [1:0] SIDE_BLACK = 2'd1;
    localparam logic [1:0] SIDE_NONE  = 2'd2;

    // Castling bits
    localparam logic [3:0] CASTLE_WK = 4'b0001;
    localparam logic [3:0] CASTLE_WQ = 4'b0010;
    localparam logic [3:0] CASTLE_BK = 4'b0100;
    localparam logic [3:0] CASTLE_BQ = 4'b1000;

    // Characters
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_0     = 8'h30;
    localparam logic [7:0] CH_1     = 8'h31;
    localparam logic [7:0] CH_8     = 8'h38;
    localparam logic [7:0] CH_9     = 8'h39;
    localparam logic [7:0] CH_A_LO  = 8'h61;
    localparam logic [7:0] CH_H_LO  = 8'h68;
    localparam logic [7:0] CH_W_LO  = 8'h77;
    localparam logic [7:0] CH_B_LO  = 8'h62;
    localparam logic [7:0] CH_K_UP  = 8'h4B;
    localparam logic [7:0] CH_Q_UP  = 8'h51;
    localparam logic [7:0] CH_K_LO  = 8'h6B;
    localparam logic [7:0] CH_Q_LO  = 8'h71;

    // Position snapshot handed from the parser to the word emitter
    typedef struct packed {
        logic [NUM_PIECES-1:0][63:0] boards;
        logic [3:0]                  castle;
        logic [1:0]                  side;
        logic [6:0]                  ep;
        logic [16:0]                 half;
        logic [16:0]                 full;
    } t_snap;

    // Piece letter decode: bit 4 = letter is a piece, bits 3:0 = board slot
    function automatic logic [4:0] piece_slot(input logic [7:0] c);
        logic [4:0] r;
        unique case (c)
            8'h50:   r = {1'b1, 4'd0};   // P
            8'h4E:   r = {1'b1, 4'd1};   // N
            8'h42:   r = {1'b1, 4'd2};   // B
            8'h52:   r = {1'b1, 4'd3};   // R
            8'h51:   r = {1'b1, 4'd4};   // Q
            8'h4B:   r = {1'b1, 4'd5};   // K
            8'h70:   r = {1'b1, 4'd6};   // p
            8'h6E:   r = {1'b1, 4'd7};   // n
            8'h62:   r = {1'b1, 4'd8};   // b
            8'h72:   r = {1'b1, 4'd9};   // r
            8'h71:   r = {1'b1, 4'd10};  // q
            8'h6B:   r = {1'b1, 4'd11};  // k
            default: r = 5'd0;
        endcase
        return r;
    endfunction

endpackage

// File: rtl/fenbb_parse.sv
// Position parse state: boards, cursor, field count and scalar fields.
// Updates once per taken item; depends on fenbb_pkg.
module fenbb_parse (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_take,
    input  logic [7:0]           i_byte,
    input  logic                 i_eot,
    output fenbb_pkg::t_snap     o_snap
);

    logic [fenbb_pkg::NUM_PIECES-1:0][63:0] r_boards, n_boards;
    logic [3:0]  r_rank, n_rank;
    logic [3:0]  r_file, n_file;
    logic [2:0]  r_field, n_field;
    logic [3:0]  r_castle, n_castle;
    logic [1:0]  r_side, n_side;
    logic [6:0]  r_ep, n_ep;
    logic        r_ep_pend, n_ep_pend;
    logic [2:0]  r_ep_file, n_ep_file;
    logic        r_half_given, n_half_given;
    logic [15:0] r_half, n_half;
    logic        r_full_given, n_full_given;
    logic [15:0] r_full, n_full;
    logic        r_half_act, n_half_act;
    logic        r_full_act, n_full_act;

    logic [4:0]  slot;
    logic        is_digit;
    logic [3:0]  digit;
    logic [4:0]  file_sum;

    // Saturating value*10 + digit
    function automatic logic [15:0] mac10(input logic [15:0] v, input logic [3:0] d);
        logic [19:0] s;
        s = {1'b0, v, 3'b000} + {3'b000, v, 1'b0} + {16'd0, d};
        return (s > {4'd0, fenbb_pkg::COUNT_MAX}) ? fenbb_pkg::COUNT_MAX : s[15:0];
    endfunction

    assign slot     = fenbb_pkg::piece_slot(i_byte);
    assign is_digit = (i_byte >= fenbb_pkg::CH_0) && (i_byte <= fenbb_pkg::CH_9);
    assign digit    = 4'(i_byte - fenbb_pkg::CH_0);
    assign file_sum = {1'b0, r_file} + {1'b0, digit};

    always_comb begin
        n_boards     = r_boards;
        n_rank       = r_rank;
        n_file       = r_file;
        n_field      = r_field;
        n_castle     = r_castle;
        n_side       = r_side;
        n_ep         = r_ep;
        n_ep_pend    = r_ep_pend;
        n_ep_file    = r_ep_file;
        n_half_given = r_half_given;
        n_half       = r_half;
        n_full_given = r_full_given;
        n_full       = r_full;
        n_half_act   = r_half_act;
        n_full_act   = r_full_act;

        if (i_byte == fenbb_pkg::CH_SPACE) begin
            if (r_field < fenbb_pkg::FIELD_MAX) begin
                n_field = r_field + 3'd1;
            end
            n_ep_pend  = 1'b0;
            n_ep_file  = 3'd0;
            n_half_act = 1'b0;
            n_full_act = 1'b0;
        end else begin
            unique case (r_field)
                fenbb_pkg::FIELD_PLACE: begin
                    if (slot[4]) begin
                        if (r_rank < 4'd8 && r_file < 4'd8) begin
                            n_boards[slot[3:0]][{r_rank[2:0], r_file[2:0]}] = 1'b1;
                        end
                        if (r_file < fenbb_pkg::FILE_MAX) begin
                            n_file = r_file + 4'd1;
                        end
                    end else if (is_digit) begin
                        n_file = (file_sum > {1'b0, fenbb_pkg::FILE_MAX}) ?
                                 fenbb_pkg::FILE_MAX : file_sum[3:0];
                    end else if (i_byte == fenbb_pkg::CH_SLASH) begin
                        n_file = 4'd0;
                        n_rank = (r_rank == 4'd0 || r_rank > fenbb_pkg::TOP_RANK) ?
                                 fenbb_pkg::OFF_RANK : r_rank - 4'd1;
                    end
                end
                fenbb_pkg::FIELD_SIDE: begin
                    if (i_byte == fenbb_pkg::CH_W_LO) begin
                        n_side = fenbb_pkg::SIDE_WHITE;
                    end else if (i_byte == fenbb_pkg::CH_B_LO) begin
                        n_side = fenbb_pkg::SIDE_BLACK;
                    end
                end
                fenbb_pkg::FIELD_CASTLE: begin
                    if (i_byte == fenbb_pkg::CH_K_UP) begin
                        n_castle = r_castle | fenbb_pkg::CASTLE_WK;
                    end else if (i_byte == fenbb_pkg::CH_Q_UP) begin
                        n_castle = r_castle | fenbb_pkg::CASTLE_WQ;
                    end else if (i_byte == fenbb_pkg::CH_K_LO) begin
                        n_castle = r_castle | fenbb_pkg::CASTLE_BK;
                    end else if (i_byte == fenbb_pkg::CH_Q_LO) begin
                        n_castle = r_castle | fenbb_pkg::CASTLE_BQ;
                    end
                end
                fenbb_pkg::FIELD_EP: begin
                    if (i_byte >= fenbb_pkg::CH_A_LO && i_byte <= fenbb_pkg::CH_H_LO) begin
                        n_ep_pend = 1'b1;
                        n_ep_file = 3'(i_byte - fenbb_pkg::CH_A_LO);
                    end else begin
                        if (r_ep_pend && i_byte >= fenbb_pkg::CH_1 &&
                            i_byte <= fenbb_pkg::CH_8) begin
                            n_ep = {1'b0, 3'(i_byte - fenbb_pkg::CH_1), r_ep_file};
                        end
                        n_ep_pend = 1'b0;
                        n_ep_file = 3'd0;
                    end
                end
                fenbb_pkg::FIELD_HALF: begin
                    if (is_digit) begin
                        // first digit of the field starts the count
                        if (!r_half_given || r_half_act) begin
                            n_half_given = 1'b1;
                            n_half_act   = 1'b1;
                            n_half       = mac10(r_half_given ? r_half : 16'd0, digit);
                        end
                    end else begin
                        n_half_act = 1'b0;
                    end
                end
                fenbb_pkg::FIELD_FULL: begin
                    if (is_digit) begin
                        if (!r_full_given || r_full_act) begin
                            n_full_given = 1'b1;
                            n_full_act   = 1'b1;
                            n_full       = mac10(r_full_given ? r_full : 16'd0, digit);
                        end
                    end else begin
                        n_full_act = 1'b0;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_take && i_eot)) begin
            r_boards     <= '0;
            r_rank       <= fenbb_pkg::TOP_RANK;
            r_file       <= 4'd0;
            r_field      <= fenbb_pkg::FIELD_PLACE;
            r_castle     <= 4'd0;
            r_side       <= fenbb_pkg::SIDE_NONE;
            r_ep         <= fenbb_pkg::EP_NONE;
            r_ep_pend    <= 1'b0;
            r_ep_file    <= 3'd0;
            r_half_given <= 1'b0;
            r_half       <= 16'd0;
            r_full_given <= 1'b0;
            r_full       <= 16'd0;
            r_half_act   <= 1'b0;
            r_full_act   <= 1'b0;
        end else if (i_take) begin
            r_boards     <= n_boards;
            r_rank       <= n_rank;
            r_file       <= n_file;
            r_field      <= n_field;
            r_castle     <= n_castle;
            r_side       <= n_side;
            r_ep         <= n_ep;
            r_ep_pend    <= n_ep_pend;
            r_ep_file    <= n_ep_file;
            r_half_given <= n_half_given;
            r_half       <= n_half;
            r_full_given <= n_full_given;
            r_full       <= n_full;
            r_half_act   <= n_half_act;
            r_full_act   <= n_full_act;
        end
    end

    assign o_snap.boards = r_boards;
    assign o_snap.castle = r_castle;
    assign o_snap.side   = r_side;
    assign o_snap.ep     = r_ep;
    assign o_snap.half   = r_half_given ? {1'b0, r_half} : '1;
    assign o_snap.full   = r_full_given ? {1'b0, r_full} : '1;

endmodule

// File: rtl/fenbb_dump.sv
// Word emitter: holds a snapshot of a finished position and sends its fifteen words.
// Owns the output register; depends on fenbb_pkg.
module fenbb_dump (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  fenbb_pkg::t_snap     i_snap,
    output logic                 o_busy,
    output logic                 o_valid,
    input  logic                 i_stall,
    output logic [3:0]           o_word_index,
    output logic [63:0]          o_board_word,
    output logic [3:0]           o_castle_rights,
    output logic [1:0]           o_side_to_move,
    output logic [6:0]           o_en_passant,
    output logic signed [16:0]   o_half_moves,
    output logic signed [16:0]   o_full_moves,
    output logic                 o_last_word
);

    fenbb_pkg::t_snap r_snap;
    logic        r_busy;
    logic [3:0]  r_word;
    logic        r_valid;
    logic [3:0]  r_out_index;
    logic [63:0] r_out_board;
    logic [3:0]  r_out_castle;
    logic [1:0]  r_out_side;
    logic [6:0]  r_out_ep;
    logic [16:0] r_out_half;
    logic [16:0] r_out_full;
    logic        r_out_last;

    logic        emit;
    logic [63:0] white_occ;
    logic [63:0] black_occ;
    logic [63:0] sel_board;

    assign emit = r_busy && (!r_valid || !i_stall);

    always_comb begin
        white_occ = '0;
        black_occ = '0;
        for (int k = 0; k < fenbb_pkg::NUM_PIECES / 2; k++) begin
            white_occ = white_occ | r_snap.boards[k];
            black_occ = black_occ | r_snap.boards[k + fenbb_pkg::NUM_PIECES / 2];
        end
    end

    always_comb begin
        priority if (r_word == fenbb_pkg::WORD_WHITE) begin
            sel_board = white_occ;
        end else if (r_word == fenbb_pkg::WORD_BLACK) begin
            sel_board = black_occ;
        end else if (r_word == fenbb_pkg::WORD_ALL) begin
            sel_board = white_occ | black_occ;
        end else if (r_word < 4'(fenbb_pkg::NUM_PIECES)) begin
            sel_board = r_snap.boards[r_word];
        end else begin
            sel_board = '0;
        end
    end

    // Control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_word  <= 4'd0;
            r_valid <= 1'b0;
        end else begin
            if (i_start) begin
                r_busy <= 1'b1;
                r_word <= 4'd0;
            end else if (emit) begin
                r_word <= r_word + 4'd1;
                if (r_word == fenbb_pkg::WORD_ALL) begin
                    r_busy <= 1'b0;
                end
            end
            if (emit) begin
                r_valid <= 1'b1;
            end else if (!i_stall) begin
                r_valid <= 1'b0;
            end
        end
    end

    // Payload
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_snap <= i_snap;
        end
        if (emit) begin
            r_out_index  <= r_word;
            r_out_board  <= sel_board;
            r_out_castle <= r_snap.castle;
            r_out_side   <= r_snap.side;
            r_out_ep     <= r_snap.ep;
            r_out_half   <= r_snap.half;
            r_out_full   <= r_snap.full;
            r_out_last   <= (r_word == fenbb_pkg::WORD_ALL);
        end
    end

    assign o_busy          = r_busy;
    assign o_valid         = r_valid;
    assign o_word_index    = r_out_index;
    assign o_board_word    = r_out_board;
    assign o_castle_rights = r_out_castle;
    assign o_side_to_move  = r_out_side;
    assign o_en_passant    = r_out_ep;
    assign o_half_moves    = r_out_half;
    assign o_full_moves    = r_out_full;
    assign o_last_word     = r_out_last;

endmodule

// File: rtl/fen_text_to_bitboards_core.sv
// Top level of the streaming FEN parser: input register, parse state, word emitter.
// Depends on fenbb_pkg, fenbb_parse and fenbb_dump.
//
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+-----------------------------------------
//  input   | in        | i_valid / o_stall    | i_text_byte, i_end_of_text
//  result  | out       | o_valid / i_stall    | o_word_index, o_board_word, o_castle_rights,
//          |           |                      | o_side_to_move, o_en_passant, o_half_moves,
//          |           |                      | o_full_moves, o_last_word
//
// Cycles: one text byte per cycle, sustained unless an end-of-text waits for the emitter;
// each byte is parsed in the cycle after it enters the input register. An end-of-text
// item snapshots the position, clears the parse state and hands the snapshot to the
// emitter, which sends fifteen words at one per cycle while i_stall is low. The emitter holds
// one snapshot, so a second end-of-text stalls the input until the previous run's last
// word has been loaded into the output register; ordinary bytes keep flowing meanwhile.
// Reset: synchronous, active low; clears the position, the emitter and both valids.
// Stalls: the output register holds a valid word while i_stall is high; o_stall is high
// only when the input register is full and its item cannot be taken this cycle.
module fen_text_to_bitboards_core (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // input channel
    input  logic                 i_valid,
    output logic                 o_stall,
    input  logic [7:0]           i_text_byte,
    input  logic                 i_end_of_text,
    // result channel
    output logic                 o_valid,
    input  logic                 i_stall,
    output logic [3:0]           o_word_index,
    output logic [63:0]          o_board_word,
    output logic [3:0]           o_castle_rights,
    output logic [1:0]           o_side_to_move,
    output logic [6:0]           o_en_passant,
    output logic signed [16:0]   o_half_moves,
    output logic signed [16:0]   o_full_moves,
    output logic                 o_last_word
);

    logic        r_in_valid;
    logic [7:0]  r_in_byte;
    logic        r_in_eot;

    logic        take;
    logic        accept;
    logic        dump_busy;
    fenbb_pkg::t_snap snap;

    // Take the held item: any byte at once, end of text only when the emitter is free
    assign take    = r_in_valid && (!r_in_eot || !dump_busy);
    assign o_stall = r_in_valid && !take;
    assign accept  = i_valid && !o_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (accept) begin
            r_in_valid <= 1'b1;
        end else if (take) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_in_byte <= i_text_byte;
            r_in_eot  <= i_end_of_text;
        end
    end

    fenbb_parse u_parse (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_take  (take),
        .i_byte  (r_in_byte),
        .i_eot   (r_in_eot),
        .o_snap  (snap)
    );

    fenbb_dump u_dump (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_start         (take && r_in_eot),
        .i_snap          (snap),
        .o_busy          (dump_busy),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_word_index    (o_word_index),
        .o_board_word    (o_board_word),
        .o_castle_rights (o_castle_rights),
        .o_side_to_move  (o_side_to_move),
        .o_en_passant    (o_en_passant),
        .o_half_moves    (o_half_moves),
        .o_full_moves    (o_full_moves),
        .o_last_word     (o_last_word)
    );

endmodule
